FILE: rtl/wtdds_pkg.sv
// Shared types, widths and codes for the wavetable oscillator.
// No dependencies; compiled first.
package wtdds_pkg;

  // Table geometry
  localparam int TABLE_POINTS = 1024;
  localparam int TABLE_COUNT  = 8;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int TBL_W        = $clog2(TABLE_COUNT);
  localparam int ADDR_W       = TBL_W + IDX_W;
  localparam int WAVE_DEPTH   = TABLE_COUNT * TABLE_POINTS;
  localparam int TAPS         = 4;

  // Field widths
  localparam int WORD_W      = 16;
  localparam int PHASE_W     = 16;
  localparam int FRAC_W      = 6;
  localparam int SEL_W       = 3;
  localparam int MODE_W      = 2;
  localparam int LOAD_TBL_W  = 3;
  localparam int LOAD_ADDR_W = 10;
  localparam int DAC_W       = 16;
  localparam int VOL_SHIFT   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: shared signed multiplier A x B
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 28;
  localparam int CR_W    = 20;
  localparam int H_W     = 10;
  localparam int T_W     = 7;

  localparam logic [DAC_W-1:0] DAC_OFFSET = DAC_W'(2048);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP     = 2'd3;

  // Interpolation modes
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CATMULL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  // Command opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/wtdds_if.sv
// Valid/ready channel interfaces for the oscillator: command in, DAC code out.
// Depends on wtdds_pkg.
interface wtdds_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [wtdds_pkg::LOAD_TBL_W-1:0]       load_table;
  logic [wtdds_pkg::LOAD_ADDR_W-1:0]      load_address;
  logic signed [wtdds_pkg::WORD_W-1:0]    load_word;

  modport source (output valid, opcode, load_table, load_address, load_word, input ready);
  modport sink (input valid, opcode, load_table, load_address, load_word, output ready);
endinterface

interface wtdds_dac_if;
  logic                            valid;
  logic                            ready;
  logic [wtdds_pkg::DAC_W-1:0]     dac_code;

  modport source (output valid, dac_code, input ready);
  modport sink (input valid, dac_code, output ready);
endinterface

FILE: rtl/wavetable_dds_interpolating_oscillator.sv
// Interpolating wavetable oscillator: phase accumulator, table RAM, shared multiplier.
// Depends on wtdds_pkg and the channel interfaces in wtdds_if.sv.
//
//   channel   dir  handshake      payload
//   cmd       in   valid/ready    opcode, load_table, load_address, load_word
//   dac       out  valid/ready    dac_code
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// A load is written to the table as it is accepted. In a tick, four taps come one per cycle
// through the single RAM port, then the shared multiplier steps through the mode's
// products.
// Reset clears phase, registers and sequencer; table contents are not cleared.
// cmd is taken only when idle; a finished tick waits while the output register is full.
module wavetable_dds_interpolating_oscillator (
  input  logic                               clk,
  input  logic                               rst,
  wtdds_cmd_if.sink                          cmd,
  wtdds_dac_if.source                        dac,
  input  logic                               cfg_we,
  input  logic [wtdds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wtdds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wtdds_pkg::*;

  // Configuration and phase
  logic [WORD_W-1:0]   volume;
  logic [PHASE_W-1:0]  phase_step;
  logic [SEL_W-1:0]    table_select;
  logic [MODE_W-1:0]   interp_mode;
  logic [PHASE_W-1:0]  phase;

  // Sequencer
  state_t      state, state_next;
  logic [2:0]  rd_cnt;
  logic [2:0]  rd_prev;
  logic [2:0]  step;
  logic        calc_last;
  logic        cmd_ready;
  logic        mem_we;
  logic        load_out;

  // Table RAM
  logic signed [WORD_W-1:0] wave_store [WAVE_DEPTH];
  logic [ADDR_W-1:0]        mem_addr;
  logic signed [WORD_W-1:0] mem_rdata;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         tap_idx;

  // Datapath
  logic signed [WORD_W-1:0]  x [TAPS];
  logic [T_W-1:0]            t2, t3;
  logic signed [MUL_A_W-1:0] acc;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [DAC_W-1:0]          dac_code;
  logic                      out_valid;

  logic signed [H_W-1:0]     fs, t2s, t3s, h00, h10, h01, h11;
  logic signed [WORD_W:0]    d10, m0, m1;
  logic signed [CR_W-1:0]    xm1e, x0e, x1e, x2e, c3, c2;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= '0;
      phase_step   <= '0;
      table_select <= '0;
      interp_mode  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME:     volume       <= cfg_data[WORD_W-1:0];
        REG_PHASE_STEP: phase_step   <= cfg_data[PHASE_W-1:0];
        REG_TABLE_SEL:  table_select <= cfg_data[SEL_W-1:0];
        REG_INTERP:     interp_mode  <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd.valid && cmd.opcode == OP_TICK) state_next = ST_READ;
      ST_READ:  if (rd_cnt == 3'(TAPS)) state_next = ST_CALC;
      ST_CALC:  if (calc_last) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        mem_we    = cmd.valid && cmd.opcode == OP_LOAD
                    && 32'(cmd.load_table) < TABLE_COUNT
                    && 32'(cmd.load_address) < TABLE_POINTS;
      end
      ST_DONE: load_out = !out_valid || dac.ready;
      default: ;
    endcase
  end

  // Last calculation step for each mode
  always_comb begin
    case (interp_mode)
      MODE_LINEAR:  calc_last = (step == 3'd1);
      MODE_HERMITE: calc_last = (step == 3'd7);
      MODE_CATMULL: calc_last = (step == 3'd3);
      default:      calc_last = 1'b1;
    endcase
  end

  // RAM address: load word on accept, else the current tap (wrapping in the table)
  assign idx     = phase[FRAC_W +: IDX_W];
  assign tap_idx = idx + IDX_W'(rd_cnt[1:0]) - IDX_W'(1);
  assign mem_addr = (state == ST_IDLE)
                    ? {cmd.load_table[TBL_W-1:0], cmd.load_address[IDX_W-1:0]}
                    : {table_select[TBL_W-1:0], tap_idx};

  // Single-port table RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) wave_store[mem_addr] <= cmd.load_word;
    mem_rdata <= wave_store[mem_addr];
  end

  // Interpolation terms from the captured taps
  assign fs  = $signed({{(H_W-FRAC_W){1'b0}}, phase[FRAC_W-1:0]});
  assign t2s = $signed({{(H_W-T_W){1'b0}}, t2});
  assign t3s = $signed({{(H_W-T_W){1'b0}}, t3});
  assign h00 = (t3s <<< 1) - (t2s <<< 1) - t2s + H_W'(64);
  assign h10 = t3s - (t2s <<< 1) + fs;
  assign h01 = (t2s <<< 1) + t2s - (t3s <<< 1);
  assign h11 = t3s - t2s;

  assign d10 = (WORD_W+1)'(x[2]) - (WORD_W+1)'(x[1]);
  assign m0  = ((WORD_W+1)'(x[2]) - (WORD_W+1)'(x[0])) >>> 1;
  assign m1  = ((WORD_W+1)'(x[3]) - (WORD_W+1)'(x[1])) >>> 1;

  assign xm1e = CR_W'(x[0]);
  assign x0e  = CR_W'(x[1]);
  assign x1e  = CR_W'(x[2]);
  assign x2e  = CR_W'(x[3]);
  assign c3 = ((x0e <<< 1) + x0e - xm1e - (x1e <<< 1) - x1e + x2e) >>> 1;
  assign c2 = ((xm1e <<< 1) - (x0e <<< 2) - x0e + (x1e <<< 2) - x2e) >>> 1;

  // Shared multiplier operand select
  always_comb begin
    mul_a = acc;
    mul_b = $signed({1'b0, volume});
    if (state == ST_CALC) begin
      mul_b = MUL_B_W'(fs);
      case (interp_mode)
        MODE_LINEAR: mul_a = MUL_A_W'(d10);
        MODE_HERMITE: begin
          case (step)
            3'd0: mul_a = MUL_A_W'(fs);
            3'd1: mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, prod[FRAC_W +: T_W]});
            3'd3: begin mul_a = MUL_A_W'(x[1]); mul_b = MUL_B_W'(h00); end
            3'd4: begin mul_a = MUL_A_W'(m0);   mul_b = MUL_B_W'(h10); end
            3'd5: begin mul_a = MUL_A_W'(x[2]); mul_b = MUL_B_W'(h01); end
            3'd6: begin mul_a = MUL_A_W'(m1);   mul_b = MUL_B_W'(h11); end
            default: ;
          endcase
        end
        MODE_CATMULL: begin
          case (step)
            3'd0: mul_a = MUL_A_W'(c3);
            3'd1: mul_a = MUL_A_W'(prod >>> FRAC_W) + MUL_A_W'(c2);
            3'd2: mul_a = MUL_A_W'(prod >>> FRAC_W) + MUL_A_W'(m0);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Tap capture, calculation steps and the volume product
  assign rd_prev = rd_cnt - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      step   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_cnt <= '0;
          step   <= '0;
        end
        ST_READ: rd_cnt <= rd_cnt + 3'd1;
        ST_CALC: step <= step + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ && rd_cnt != 3'd0) x[rd_prev[1:0]] <= mem_rdata;
    if (state == ST_CALC || state == ST_SCALE) prod <= mul_a * mul_b;
    if (state == ST_CALC) begin
      case (interp_mode)
        MODE_LINEAR:
          if (step == 3'd1) acc <= MUL_A_W'(x[1]) + MUL_A_W'(prod >>> FRAC_W);
        MODE_HERMITE: begin
          case (step)
            3'd1: t2 <= prod[FRAC_W +: T_W];
            3'd2: t3 <= prod[FRAC_W +: T_W];
            3'd3: sum <= '0;
            3'd4, 3'd5, 3'd6: sum <= sum + SUM_W'(prod);
            3'd7: acc <= MUL_A_W'((sum + SUM_W'(prod)) >>> FRAC_W);
            default: ;
          endcase
        end
        MODE_CATMULL:
          if (step == 3'd3) acc <= MUL_A_W'(prod >>> FRAC_W) + MUL_A_W'(x[1]);
        default: acc <= MUL_A_W'(x[1]);
      endcase
    end
  end

  // Output register and phase advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        phase     <= phase + phase_step;
      end else if (dac.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) dac_code <= prod[VOL_SHIFT +: DAC_W] + DAC_OFFSET;
  end

  assign cmd.ready    = cmd_ready;
  assign dac.valid    = out_valid;
  assign dac.dac_code = dac_code;

  // Checks
  a_tick_starts_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.opcode == OP_TICK) |=> state == ST_READ)
    else $error("accepted tick did not start tap reads");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared outside the done state");

  a_phase_on_result: assert property (@(posedge clk) disable iff (rst)
    (phase != $past(phase)) |-> ($past(state == ST_DONE) || $past(rst)))
    else $error("phase moved without a delivered tick");

  a_blocked_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !dac.ready) |=> state == ST_DONE)
    else $error("finished tick left while output register was full");

  a_no_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !mem_we && !cmd.ready)
    else $error("table written or command taken during a tick");

endmodule

FILE: sim/wtdds_dac_check.sv
// Checker for the wavetable oscillator: watches the command, DAC and register ports,
// predicts every DAC code and compares it with what the block emits.
// Depends on wtdds_pkg and the channel interfaces in wtdds_if.sv.
module wtdds_dac_check (
  input  logic                             clk,
  input  logic                             rst,
  wtdds_cmd_if                             cmd,
  wtdds_dac_if                             dac,
  input  logic                             cfg_we,
  input  logic [wtdds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtdds_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import wtdds_pkg::*;

  // Shadow copy of the registers, phase and wave tables
  logic [WORD_W-1:0]        vol_q;
  logic [PHASE_W-1:0]       step_q;
  logic [SEL_W-1:0]         sel_q;
  logic [MODE_W-1:0]        mode_q;
  logic [PHASE_W-1:0]       phase_q;
  logic signed [WORD_W-1:0] wave_mem [WAVE_DEPTH];

  // DAC codes owed by ticks already taken, oldest first
  logic [DAC_W-1:0] dac_expected_q [$];
  int               mismatches = 0;

  // One tap of the selected table; neighbours wrap within the table
  function automatic longint wave_tap(logic [IDX_W-1:0] idx, int delta);
    logic [IDX_W-1:0] pos;
    pos = idx + IDX_W'(delta);
    return longint'(wave_mem[{sel_q, pos}]);
  endfunction

  // Interpolate at the current phase, scale by volume and add the DAC offset.
  // All right shifts are arithmetic (floor) on 64-bit signed values.
  function automatic logic [DAC_W-1:0] predict_dac_code();
    logic [IDX_W-1:0] idx;
    longint f, xm1, x0, x1, x2, s, y;
    longint t2, t3, m0, m1, c1, c2, c3, acc;
    idx = phase_q[PHASE_W-1:FRAC_W];
    f   = longint'(phase_q[FRAC_W-1:0]);
    xm1 = wave_tap(idx, -1);
    x0  = wave_tap(idx, 0);
    x1  = wave_tap(idx, 1);
    x2  = wave_tap(idx, 2);
    case (mode_q)
      MODE_LINEAR: begin
        s = x0 + (((x1 - x0) * f) >>> 6);
      end
      MODE_HERMITE: begin
        t2 = (f * f) >>> 6;
        t3 = (t2 * f) >>> 6;
        m0 = (x1 - xm1) >>> 1;
        m1 = (x2 - x0) >>> 1;
        s  = ((2 * t3 - 3 * t2 + 64) * x0 + (t3 - 2 * t2 + f) * m0
              + (3 * t2 - 2 * t3) * x1 + (t3 - t2) * m1) >>> 6;
      end
      MODE_CATMULL: begin
        c3  = (3 * x0 - xm1 - 3 * x1 + x2) >>> 1;
        c2  = (2 * xm1 - 5 * x0 + 4 * x1 - x2) >>> 1;
        c1  = (x1 - xm1) >>> 1;
        acc = (c3 * f) >>> 6;
        acc = ((acc + c2) * f) >>> 6;
        acc = ((acc + c1) * f) >>> 6;
        s   = acc + x0;
      end
      default: begin
        s = x0;
      end
    endcase
    // full-width product, never saturated; only the low bits go out
    y = ((s * longint'(vol_q)) >>> VOL_SHIFT) + longint'(DAC_OFFSET);
    return DAC_W'(y);
  endfunction

  // Track registers, commands and DAC transactions at each rising edge
  always @(posedge clk) begin
    logic [DAC_W-1:0] want;
    if (rst) begin
      vol_q   = '0;
      step_q  = '0;
      sel_q   = '0;
      mode_q  = MODE_LINEAR;
      phase_q = '0;
      dac_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VOLUME:     vol_q  = cfg_data[WORD_W-1:0];
          REG_PHASE_STEP: step_q = cfg_data[PHASE_W-1:0];
          REG_TABLE_SEL:  sel_q  = cfg_data[SEL_W-1:0];
          REG_INTERP:     mode_q = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      // compare the emitted code with the oldest prediction
      if (dac.valid && dac.ready) begin
        if (dac_expected_q.size() == 0) begin
          mismatches++;
          $display("%0t dac_code %h arrived with no tick outstanding", $time, dac.dac_code);
        end else begin
          want = dac_expected_q.pop_front();
          if (dac.dac_code !== want) begin
            mismatches++;
            $display("%0t dac_code mismatch: expected %h, actual %h",
                     $time, want, dac.dac_code);
          end
        end
      end

      // a load writes one word; a tick owes one code and advances the phase
      if (cmd.valid && cmd.ready) begin
        if (cmd.opcode == OP_LOAD) begin
          wave_mem[{cmd.load_table, cmd.load_address}] = cmd.load_word;
        end else begin
          dac_expected_q.push_back(predict_dac_code());
          phase_q = phase_q + step_q;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= dac_expected_q.size();
  end

endmodule

FILE: sim/testbench.sv
// Testbench top for the wavetable oscillator: clock, reset, register setup,
// command stimulus, DAC back-pressure and the final verdict.
// Depends on wtdds_pkg, wtdds_if.sv, the oscillator RTL and wtdds_dac_check.sv.
module testbench;
  import wtdds_pkg::*;

  localparam int NUM_SEGS   = 10;
  localparam int SEG_ITEMS  = 188;
  localparam int SETTLE     = 24;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 4000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  wtdds_cmd_if cmd_ch ();
  wtdds_dac_if dac_ch ();

  wavetable_dds_interpolating_oscillator DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .dac       (dac_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wtdds_dac_check dac_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .dac        (dac_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stimulus-side view: phase and step track the block so that no tick
  // ever reads a table entry that was never loaded
  logic [PHASE_W-1:0] phase_shadow = '0;
  logic [PHASE_W-1:0] step_shadow  = '0;
  logic [SEL_W-1:0]   sel_shadow   = '0;
  bit                 loaded [WAVE_DEPTH];
  int                 items_sent   = 0;
  int                 tx_idle_pct  = 0;
  int                 rx_stall_pct = 0;
  int                 hold_asks    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // DAC receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_done;
    int hold_left;
    hold_done = 0;
    hold_left = 0;
    dac_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        dac_ch.ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = HOLD_LEN - 1;
        dac_ch.ready <= 1'b0;
      end else begin
        dac_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (dac_ch.valid && dac_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample word, with the extremes showing up often
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Offer one command; returns at the edge where the transaction happens.
  // Ready is looked at on the falling edge, away from the block's updates.
  task automatic push_cmd(input logic op, input logic [LOAD_TBL_W-1:0] tbl,
                          input logic [LOAD_ADDR_W-1:0] addr, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.load_table   <= tbl;
    cmd_ch.load_address <= addr;
    cmd_ch.load_word    <= word;
    @(negedge clk);
    while (!cmd_ch.ready) @(negedge clk);
    @(posedge clk);
    if (op == OP_LOAD) loaded[{tbl, addr}] = 1'b1;
    items_sent++;
  endtask

  // One tick: load any of the four taps still missing, then tick
  task automatic play_tick();
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] pos;
    idx = phase_shadow[PHASE_W-1:FRAC_W];
    for (int d = -1; d <= 2; d++) begin
      pos = idx + IDX_W'(d);
      if (!loaded[{sel_shadow, pos}]) push_cmd(OP_LOAD, sel_shadow, pos, rand_word());
    end
    // load fields carry junk on a tick
    push_cmd(OP_TICK, LOAD_TBL_W'($urandom), LOAD_ADDR_W'($urandom), WORD_W'($urandom));
    phase_shadow = phase_shadow + step_shadow;
  endtask

  // Stop offering, wait for every owed code, then let the block settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic program_regs(input logic [WORD_W-1:0] vol, input logic [PHASE_W-1:0] step,
                              input logic [SEL_W-1:0] sel, input logic [MODE_W-1:0] mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_VOLUME;
    cfg_data  <= vol;
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_TABLE_SEL;
    cfg_data  <= CFG_DATA_W'(sel);
    @(posedge clk);
    cfg_index <= REG_INTERP;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_we      <= 1'b0;
    step_shadow = step;
    sel_shadow  = sel;
  endtask

  // Main sequence
  initial begin
    logic [WORD_W-1:0]  vol;
    logic [PHASE_W-1:0] step;
    logic [SEL_W-1:0]   sel;
    idle_mode_t         idle;
    int                 seg_start;
    bit                 held;
    bit                 paused;

    held   = 1'b0;
    paused = 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_TICK;
    cmd_ch.load_table   <= '0;
    cmd_ch.load_address <= '0;
    cmd_ch.load_word    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_VOLUME;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-scale alternating taps around index 0, wrap to entry 1023
    program_regs(16'hFFFF, 16'h0000, 3'd0, MODE_NONE);
    push_cmd(OP_LOAD, 3'd0, 10'd1023, 16'h7FFF);
    push_cmd(OP_LOAD, 3'd0, 10'd0, 16'h8000);
    push_cmd(OP_LOAD, 3'd0, 10'd1, 16'h7FFF);
    push_cmd(OP_LOAD, 3'd0, 10'd2, 16'h8000);
    push_cmd(OP_LOAD, 3'd0, 10'd3, 16'h7FFF);
    play_tick();

    // each interpolation mode, zero and nonzero fractions
    program_regs(16'hFFFF, 16'h0020, 3'd0, MODE_LINEAR);
    play_tick();
    play_tick();
    program_regs(16'hFFFF, 16'h001F, 3'd0, MODE_HERMITE);
    play_tick();
    play_tick();
    // cubic overshoot on alternating extremes; phase runs backwards
    program_regs(16'hFFFF, 16'hFFFF, 3'd0, MODE_CATMULL);
    play_tick();
    play_tick();
    // last table, zero volume, index stepping down through 0 to 1023
    program_regs(16'h0000, 16'hFFC0, 3'd7, MODE_NONE);
    play_tick();
    play_tick();
    play_tick();

    // Random segments, each with its own register setting and idle pattern
    for (int s = 0; s < NUM_SEGS; s++) begin
      case (s)
        0: begin
          vol  = 16'hFFFF;
          step = 16'hFFFF;
          sel  = 3'd7;
        end
        1: begin
          vol  = 16'h0000;
          step = 16'h0000;
          sel  = 3'd0;
        end
        default: begin
          case ($urandom_range(3))
            0:       vol = 16'h0000;
            1:       vol = 16'hFFFF;
            default: vol = WORD_W'($urandom);
          endcase
          case ($urandom_range(4))
            0:       step = 16'h0001;
            1:       step = 16'hFFFF;
            2:       step = PHASE_W'($urandom_range(200, 1));
            default: step = PHASE_W'($urandom);
          endcase
          sel = SEL_W'($urandom_range(7));
        end
      endcase
      program_regs(vol, step, sel, MODE_W'(s % 4));

      idle = idle_mode_t'((s / 2) % 4);
      case (idle)
        IDLE_SENDER: begin
          tx_idle_pct  = 76;
          rx_stall_pct <= 0;
        end
        IDLE_RECEIVER: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 76;
        end
        IDLE_BOTH: begin
          tx_idle_pct  = 27;
          rx_stall_pct <= 27;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 0;
        end
      endcase

      seg_start = items_sent;
      while (items_sent < seg_start + SEG_ITEMS) begin
        // long receiver hold-off while commands keep coming
        if (s == 0 && !held && items_sent >= seg_start + 40) begin
          held = 1'b1;
          hold_asks <= hold_asks + 1;
        end
        // sender waits for every owed code before going on
        if (s == 4 && !paused && items_sent >= seg_start + 90) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(99) < 30)
          push_cmd(OP_LOAD, LOAD_TBL_W'($urandom_range(7)),
                   LOAD_ADDR_W'($urandom_range(1023)), rand_word());
        else
          play_tick();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
